[rtl/sdsh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsh_pkg: shared types for the sorted drill size histogram
// Item and result structs, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdsh_pkg;

    localparam int KEY_W = 20;
    localparam int ID_W  = 16;
    localparam int CNT_W = 16;
    localparam int EC_W  = 7;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] hole_size;
        logic             is_via;
        logic [ID_W-1:0]  element_id;
        logic             unplated;
    } t_hole_item;

    typedef struct packed {
        logic [KEY_W-1:0] drill_size;
        logic [CNT_W-1:0] pin_count;
        logic [CNT_W-1:0] via_count;
        logic [CNT_W-1:0] unplated_count;
        logic [EC_W-1:0]  element_count;
        logic             entry_valid;
        logic             overflow;
        logic             last;
    } t_drill_result;

    typedef struct packed {
        logic load;
        logic step;
        logic take;
        logic insert;
        logic set_ovf;
        logic update;
        logic elem_step;
        logic elem_write;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic at_end;
        logic key_lt;
        logic key_eq;
        logic full;
        logic is_via;
        logic k_end;
        logic match;
        logic elem_full;
        logic used_zero;
        logic dump_last;
    } t_status;

endpackage

[rtl/sdsh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsh_ctrl: sequencer for the drill size histogram
// Walks a hole through key search, insertion, count update and element
// search, and steps a dump through the table.
// ----------------------------------------------------------------------------
module sdsh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_kind,
    input  sdsh_pkg::t_status i_status,
    output sdsh_pkg::t_cmd   o_cmd,
    output logic             busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_ELOOP  = 3'd3;
    localparam logic [2:0] S_DUMP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_kind ? S_DUMP : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (!i_status.at_end && i_status.key_lt) begin
                    o_cmd.step = 1'b1;
                end else if (!i_status.at_end && i_status.key_eq) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_UPD;
                end else if (i_status.full) begin
                    o_cmd.set_ovf = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.is_via ? S_IDLE : S_ELOOP;
            end
            S_ELOOP: begin
                if (i_status.k_end) begin
                    if (i_status.elem_full) begin
                        o_cmd.set_ovf = 1'b1;
                    end else begin
                        o_cmd.elem_write = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (i_status.match) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.elem_step = 1'b1;
                end
            end
            S_DUMP: begin
                o_cmd.emit = 1'b1;
                if (i_status.used_zero || i_status.dump_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[rtl/sdsh_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsh_dpath: table storage and result register
// Sorted keys with slot order, per-slot counters, the element id memory
// and the registered result.
// ----------------------------------------------------------------------------
module sdsh_dpath #(
    parameter int MAX_SIZES             = 32,
    parameter int MAX_ELEMENTS_PER_SIZE = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sdsh_pkg::t_hole_item       i_item,
    input  sdsh_pkg::t_cmd             i_cmd,
    output sdsh_pkg::t_status          o_status,
    output logic                       o_valid,
    output sdsh_pkg::t_drill_result    o_result
);

    localparam int ME    = MAX_ELEMENTS_PER_SIZE;
    localparam int SW    = $clog2(MAX_SIZES);
    localparam int UW    = $clog2(MAX_SIZES + 1);
    localparam int EW    = (ME > 1) ? $clog2(ME + 1) : 1;
    localparam int KW    = (ME > 1) ? $clog2(ME) : 1;
    localparam int DEPTH = MAX_SIZES * ME;
    localparam int AW    = $clog2(DEPTH);
    localparam int KEY_W = sdsh_pkg::KEY_W;
    localparam int CNT_W = sdsh_pkg::CNT_W;
    localparam int ID_W  = sdsh_pkg::ID_W;
    localparam int EC_W  = sdsh_pkg::EC_W;

    sdsh_pkg::t_hole_item    r_item;
    sdsh_pkg::t_drill_result r_res;
    logic                    r_valid;
    logic [UW-1:0]           r_pos;
    logic [UW-1:0]           r_used;
    logic                    r_ovf;
    logic [SW-1:0]           r_slot;
    logic [EW-1:0]           r_k;
    logic [EW-1:0]           n_k;
    logic [KEY_W-1:0]        r_key   [MAX_SIZES];
    logic [SW-1:0]           r_order [MAX_SIZES];
    logic [CNT_W-1:0]        r_pin   [MAX_SIZES];
    logic [CNT_W-1:0]        r_via   [MAX_SIZES];
    logic [CNT_W-1:0]        r_unp   [MAX_SIZES];
    logic [EW-1:0]           r_ec    [MAX_SIZES];
    logic [ID_W-1:0]         r_mem   [DEPTH];
    logic [ID_W-1:0]         r_rdata;

    logic [SW-1:0] pidx;
    logic [SW-1:0] dslot;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    assign pidx  = r_pos[SW-1:0];
    assign dslot = r_order[pidx];

    always_comb begin
        if (i_cmd.update) begin
            n_k = '0;
        end else if (i_cmd.elem_step) begin
            n_k = r_k + EW'(1);
        end else begin
            n_k = r_k;
        end
    end

    assign raddr = AW'(32'(r_slot) * ME + 32'(n_k[KW-1:0]));
    assign waddr = AW'(32'(r_slot) * ME + 32'(r_k[KW-1:0]));

    assign o_status.at_end    = (r_pos == r_used);
    assign o_status.key_lt    = (r_key[pidx] < r_item.hole_size);
    assign o_status.key_eq    = (r_key[pidx] == r_item.hole_size);
    assign o_status.full      = (r_used == UW'(MAX_SIZES));
    assign o_status.is_via    = r_item.is_via;
    assign o_status.k_end     = (r_k == r_ec[r_slot]);
    assign o_status.match     = (r_rdata == r_item.element_id);
    assign o_status.elem_full = (32'(r_ec[r_slot]) == ME);
    assign o_status.used_zero = (r_used == '0);
    assign o_status.dump_last = ((r_pos + UW'(1)) == r_used);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.insert) begin
                r_used <= r_used + UW'(1);
            end
            if (i_cmd.clear) begin
                r_used <= '0;
                r_ovf  <= 1'b0;
            end else if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // payload and table
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_pos  <= '0;
        end else if (i_cmd.step || i_cmd.emit) begin
            r_pos <= r_pos + UW'(1);
        end
        r_k <= n_k;
        if (i_cmd.take) begin
            r_slot <= dslot;
        end
        if (i_cmd.insert) begin
            r_slot <= r_used[SW-1:0];
            for (int i = 1; i < MAX_SIZES; i++) begin
                if ((UW'(i) > r_pos) && (UW'(i) <= r_used)) begin
                    r_key[i]   <= r_key[i-1];
                    r_order[i] <= r_order[i-1];
                end
            end
            r_key[pidx]             <= r_item.hole_size;
            r_order[pidx]           <= r_used[SW-1:0];
            r_pin[r_used[SW-1:0]]   <= '0;
            r_via[r_used[SW-1:0]]   <= '0;
            r_unp[r_used[SW-1:0]]   <= '0;
            r_ec[r_used[SW-1:0]]    <= '0;
        end
        if (i_cmd.update) begin
            if (r_item.is_via) begin
                if (r_via[r_slot] != '1) r_via[r_slot] <= r_via[r_slot] + CNT_W'(1);
            end else begin
                if (r_pin[r_slot] != '1) r_pin[r_slot] <= r_pin[r_slot] + CNT_W'(1);
            end
            if (r_item.unplated && (r_unp[r_slot] != '1)) begin
                r_unp[r_slot] <= r_unp[r_slot] + CNT_W'(1);
            end
        end
        if (i_cmd.elem_write) begin
            r_mem[waddr]  <= r_item.element_id;
            r_ec[r_slot]  <= r_ec[r_slot] + EW'(1);
        end
        r_rdata <= r_mem[raddr];
        if (i_cmd.emit) begin
            r_res.overflow <= r_ovf;
            if (r_used == '0) begin
                r_res.drill_size     <= '0;
                r_res.pin_count      <= '0;
                r_res.via_count      <= '0;
                r_res.unplated_count <= '0;
                r_res.element_count  <= '0;
                r_res.entry_valid    <= 1'b0;
                r_res.last           <= 1'b1;
            end else begin
                r_res.drill_size     <= r_key[pidx];
                r_res.pin_count      <= r_pin[dslot];
                r_res.via_count      <= r_via[dslot];
                r_res.unplated_count <= r_unp[dslot];
                r_res.element_count  <= (32'(r_ec[dslot]) > 127) ? 7'd127
                                        : EC_W'(32'(r_ec[dslot]));
                r_res.entry_valid    <= 1'b1;
                r_res.last           <= o_status.dump_last;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= MAX_SIZES) else $error("entry count beyond table");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (o_status.used_zero || o_status.dump_last)) |=> (r_used == '0 && !r_ovf))
        else $error("table not cleared after final dump result");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.entry_valid) |-> r_res.last)
        else $error("empty dump result not marked last");
    a_elem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.elem_write |-> !o_status.elem_full)
        else $error("element write into full set");

endmodule

[rtl/sorted_drill_size_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_drill_size_histogram: histogram of drill sizes in ascending order
// Collects hole records into a sorted size table and dumps it on request.
//
// Input: raise start with an item on i_item; it transfers at the clock edge
// where start is high and busy is low. kind 0 is a hole record, kind 1 asks
// for a dump of the table.
// A hole record walks the sorted keys one per cycle until it finds its size
// or the insertion point (or sets the overflow flag if the table is full),
// updates the counters, then, unless it is a via, walks the element ids of
// that size one per cycle from a registered memory read.
// A dump emits one result per cycle on o_result with o_valid high for
// exactly one cycle each, in ascending size order, the final one marked
// last; an empty table gives one result with entry_valid low. Each result
// is registered in the dump state, and busy falls with the final one. The
// receiver cannot stall: each result is taken in the cycle it is shown.
// Reset empties the table and clears the overflow flag; no clearing pass is
// needed since only written entries are ever read.
// ----------------------------------------------------------------------------
module sorted_drill_size_histogram #(
    parameter int MAX_SIZES             = 32,
    parameter int MAX_ELEMENTS_PER_SIZE = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  sdsh_pkg::t_hole_item    i_item,
    output logic                    o_valid,
    output sdsh_pkg::t_drill_result o_result
);

    sdsh_pkg::t_cmd    cmd;
    sdsh_pkg::t_status status;

    // sequencer: one state per phase of a hole or a dump
    sdsh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_item.kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // table storage, element memory and result register
    sdsh_dpath #(
        .MAX_SIZES             (MAX_SIZES),
        .MAX_ELEMENTS_PER_SIZE (MAX_ELEMENTS_PER_SIZE)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
